/* design/fgr_pkg.sv */
`default_nettype none

package fgr_pkg;

  localparam int DATA_WIDTH = 32;
  // Shift count of the binary GCD never exceeds DATA_WIDTH - 1.
  localparam int ShiftWidth = $clog2(DATA_WIDTH);
  // Divider step counter must hold DATA_WIDTH itself.
  localparam int StepWidth = $clog2(DATA_WIDTH + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* design/fgr_in_if.sv */
`default_nettype none

interface fgr_in_if;
  import fgr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] num_in;
  logic        [DATA_WIDTH-1:0] den_in;

  modport source (output valid, output num_in, output den_in, input ready);
  modport sink (input valid, input num_in, input den_in, output ready);

endinterface

`default_nettype wire

/* design/fgr_out_if.sv */
`default_nettype none

interface fgr_out_if;
  import fgr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] num_out;
  logic        [DATA_WIDTH-1:0] den_out;

  modport source (output valid, output num_out, output den_out, input ready);
  modport sink (input valid, input num_out, input den_out, output ready);

endinterface

`default_nettype wire

/* design/fraction_gcd_reducer.sv */
// Reduces a fraction num/den (signed numerator, unsigned denominator) by the
// greatest common divisor of the magnitudes, one request at a time. A binary
// GCD unit takes one shift or subtract step per cycle, and a shared restoring
// divider then forms numerator/gcd and denominator/gcd at one bit per cycle;
// 0/0 skips the divisions and returns 0/0. A finished result sits in the
// output register until taken, and the next request is taken once it has been
// moved there.
`default_nettype none

module fraction_gcd_reducer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fgr_in_if.sink     in_i,
  fgr_out_if.source  out_o
);
  import fgr_pkg::*;

  state_e state_q, state_d;

  logic  in_fire;
  logic  gcd_start, gcd_done;
  word_t gcd_val;
  logic  div_start, div_done, div_sel_den;
  word_t div_quot, div_dividend;
  logic  out_load;

  word_t nraw_q, nmag_q, den_q, g_q, qn_q;
  logic  neg_q;
  word_t in_nmag;
  word_t num_res;

  word_t out_num_q, out_den_q;
  logic  out_valid_q;
  word_t div_quot_den_q;

  assign in_fire = in_i.valid && in_i.ready;
  // Negating the most negative value gives 2^(W-1), which fits unsigned.
  assign in_nmag = in_i.num_in[DATA_WIDTH-1] ? word_t'(-in_i.num_in) : word_t'(in_i.num_in);

  fgr_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (in_nmag),
    .b_i     (in_i.den_in),
    .done_o  (gcd_done),
    .gcd_o   (gcd_val)
  );

  assign div_dividend = div_sel_den ? den_q : nmag_q;

  fgr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_sel_den ? g_q : gcd_val),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_GCD;
      end
      ST_GCD: begin
        if (gcd_done) state_d = (gcd_val == '0) ? ST_DONE : ST_DIV_NUM;
      end
      ST_DIV_NUM: begin
        if (div_done) state_d = ST_DIV_DEN;
      end
      ST_DIV_DEN: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = 1'b0;
    gcd_start   = 1'b0;
    div_start   = 1'b0;
    div_sel_den = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        gcd_start  = in_fire;
      end
      ST_GCD: begin
        div_start = gcd_done && (gcd_val != '0);
      end
      ST_DIV_NUM: begin
        div_sel_den = 1'b1;
        div_start   = div_done;
      end
      ST_DIV_DEN: begin
        div_sel_den = 1'b1;
      end
      ST_DONE: begin
        out_load = !out_valid_q || out_o.ready;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (g_q == '0) begin
      num_res = nraw_q;
    end else if (neg_q) begin
      num_res = word_t'(-qn_q);
    end else begin
      num_res = qn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      nraw_q <= word_t'(in_i.num_in);
      nmag_q <= in_nmag;
      den_q  <= in_i.den_in;
      neg_q  <= in_i.num_in[DATA_WIDTH-1];
    end
    if (state_q == ST_GCD && gcd_done) g_q <= gcd_val;
    if (state_q == ST_DIV_NUM && div_done) qn_q <= div_quot;
    if (out_load) begin
      out_num_q <= num_res;
      // A zero GCD means 0/0, and den_q holds that zero already.
      out_den_q <= (g_q == '0) ? den_q : div_quot_den_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV_DEN && div_done) div_quot_den_q <= div_quot;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.num_out = signed'(out_num_q);
  assign out_o.den_out = out_den_q;

endmodule

`default_nettype wire

/* design/fgr_gcd.sv */
`default_nettype none

module fgr_gcd (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire fgr_pkg::word_t a_i,
  input  wire fgr_pkg::word_t b_i,
  output logic               done_o,
  output fgr_pkg::word_t     gcd_o
);
  import fgr_pkg::*;

  word_t                 a_q, a_d;
  word_t                 b_q, b_d;
  logic [ShiftWidth-1:0] k_q, k_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  word_t                 gcd_q, gcd_d;
  logic [DATA_WIDTH:0]   diff;
  word_t                 rest;

  // One subtract serves both the compare and the difference.
  assign diff = {1'b0, a_q} - {1'b0, b_q};
  assign rest = (a_q == '0) ? b_q : a_q;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    busy_d = busy_q;
    done_d = 1'b0;
    gcd_d  = gcd_q;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (a_q == '0 || b_q == '0) begin
        // Common factors of two removed earlier are restored here.
        gcd_d  = rest << k_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + ShiftWidth'(1);
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (!diff[DATA_WIDTH]) begin
        a_d = diff[DATA_WIDTH:1];
      end else begin
        b_d = word_t'((~diff[DATA_WIDTH-1:0] + word_t'(1)) >> 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    gcd_q <= gcd_d;
  end

  assign done_o = done_q;
  assign gcd_o  = gcd_q;

endmodule

`default_nettype wire

/* design/fgr_div.sv */
`default_nettype none

module fgr_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire fgr_pkg::word_t dividend_i,
  input  wire fgr_pkg::word_t divisor_i,
  output logic                done_o,
  output fgr_pkg::word_t      quot_o
);
  import fgr_pkg::*;

  word_t                rem_q, rem_d;
  word_t                quot_q, quot_d;
  word_t                dsr_q, dsr_d;
  logic [StepWidth-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DATA_WIDTH:0]  rem_sh;
  logic [DATA_WIDTH:0]  trial;

  // Restoring division: one quotient bit per cycle, MSB first.
  assign rem_sh = {rem_q, quot_q[DATA_WIDTH-1]};
  assign trial  = rem_sh - {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = StepWidth'(DATA_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DATA_WIDTH]) begin
        rem_d  = trial[DATA_WIDTH-1:0];
        quot_d = {quot_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[DATA_WIDTH-1:0];
        quot_d = {quot_q[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - StepWidth'(1);
      if (cnt_q == StepWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* design/fgr_checker.sv */
`default_nettype none

module fgr_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_i,
  input wire logic           out_valid_i,
  input wire logic           out_ready_i,
  input wire fgr_pkg::word_t out_num_i,
  input wire fgr_pkg::word_t out_den_i
);

  // A waiting result is not dropped before it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_num_i) && $stable(out_den_i))
    else $error("stalled result changed");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second request taken while busy");

  // No result is raised straight after a request is taken, while the GCD pass runs.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared right after a request");

endmodule

bind fraction_gcd_reducer fgr_checker u_fgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_num_i   (out_o.num_out),
  .out_den_i   (out_o.den_out)
);

`default_nettype wire
